// ===== design/ibfla_pkg.sv =====
`default_nettype none

package ibfla_pkg;

    localparam logic [7:0] END_MARK = 8'hFF;

    localparam logic [1:0] REQ_INIT     = 2'd0;
    localparam logic [1:0] REQ_ALLOC    = 2'd1;
    localparam logic [1:0] REQ_FREE     = 2'd2;
    localparam logic [1:0] REQ_FREE_ALL = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic [3:0] PC_DONE = 4'd0;
    localparam logic [3:0] PC_A0   = 4'd1;
    localparam logic [3:0] PC_A1   = 4'd2;
    localparam logic [3:0] PC_A2   = 4'd3;
    localparam logic [3:0] PC_A3   = 4'd4;
    localparam logic [3:0] PC_F0   = 4'd5;
    localparam logic [3:0] PC_R1   = 4'd6;
    localparam logic [3:0] PC_R2   = 4'd7;
    localparam logic [3:0] PC_R3   = 4'd8;
    localparam logic [3:0] PC_R4   = 4'd9;
    localparam logic [3:0] PC_R5   = 4'd10;
    localparam logic [3:0] PC_L0   = 4'd11;
    localparam logic [3:0] PC_L1   = 4'd12;
    localparam logic [3:0] PC_I0   = 4'd13;
    localparam logic [3:0] PC_I1   = 4'd14;
    localparam logic [3:0] PC_I2   = 4'd15;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_FH_EMPTY,
        COND_BIDX_OOR,
        COND_BLK_IS_ROOT,
        COND_IS_FREE,
        COND_WALK_END,
        COND_ROOT_OOR,
        COND_CNT_ZERO,
        COND_INIT_LAST
    } cond_t;

    typedef enum logic [1:0] {RD_NONE, RD_FH, RD_BIDX, RD_ROOT} rd_sel_t;
    typedef enum logic [1:0] {FH_KEEP, FH_NX, FH_BLK, FH_ZERO} fh_sel_t;
    typedef enum logic [1:0] {ROOT_KEEP, ROOT_NX, ROOT_BLK} root_sel_t;
    typedef enum logic [1:0] {WN_NONE, WN_BLK, WN_PV, WN_IDX} wn_addr_t;
    typedef enum logic [1:0] {WND_ROOT, WND_NX, WND_FH, WND_INIT} wn_data_t;
    typedef enum logic [2:0] {WP_NONE, WP_BLK, WP_NX, WP_ROOT, WP_FH, WP_IDX} wp_addr_t;
    typedef enum logic [1:0] {WPD_END, WPD_BLK, WPD_PV, WPD_INIT} wp_data_t;

    typedef struct packed {
        logic       fin;
        cond_t      cond;
        logic [3:0] tgt_t;
        logic [3:0] tgt_f;
        logic [1:0] jump_status;
        rd_sel_t    rd_sel;
        logic       ld_blk;
        logic       ld_links;
        fh_sel_t    fh_sel;
        root_sel_t  root_sel;
        logic       ld_grant;
        logic       cnt_inc;
        wn_addr_t   wn_addr;
        wn_data_t   wn_data;
        wp_addr_t   wp_addr;
        wp_data_t   wp_data;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        fin: 1'b0, cond: COND_ALWAYS, tgt_t: PC_DONE, tgt_f: PC_DONE,
        jump_status: STATUS_OK, rd_sel: RD_NONE, ld_blk: 1'b0, ld_links: 1'b0,
        fh_sel: FH_KEEP, root_sel: ROOT_KEEP, ld_grant: 1'b0, cnt_inc: 1'b0,
        wn_addr: WN_NONE, wn_data: WND_ROOT, wp_addr: WP_NONE, wp_data: WPD_END
    };

    function automatic logic [3:0] entry_pc(input logic [1:0] req);
        logic [3:0] pc;
        unique case (req)
            REQ_INIT:     pc = PC_I0;
            REQ_ALLOC:    pc = PC_A0;
            REQ_FREE:     pc = PC_F0;
            REQ_FREE_ALL: pc = PC_L0;
            default:      pc = PC_DONE;
        endcase
        return pc;
    endfunction

    // Microprogram: alloc, free with its unlink routine, the free-all walk
    // that reuses that routine, and the init sweep.
    function automatic ctrl_word_t rom(input logic [3:0] pc);
        ctrl_word_t w;
        w = CW_NOP;
        unique case (pc)
            PC_DONE: begin
                w.fin = 1'b1;
            end
            PC_A0: begin
                w.rd_sel = RD_FH;
                w.ld_blk = 1'b1;
                w.cond = COND_FH_EMPTY;
                w.tgt_t = PC_DONE;
                w.tgt_f = PC_A1;
                w.jump_status = STATUS_NO_FREE;
            end
            PC_A1: begin
                w.ld_links = 1'b1;
                w.wn_addr = WN_BLK;
                w.wn_data = WND_ROOT;
                w.wp_addr = WP_BLK;
                w.wp_data = WPD_END;
                w.tgt_t = PC_A2;
            end
            PC_A2: begin
                w.fh_sel = FH_NX;
                w.wp_addr = WP_NX;
                w.wp_data = WPD_END;
                w.tgt_t = PC_A3;
            end
            PC_A3: begin
                w.wp_addr = WP_ROOT;
                w.wp_data = WPD_BLK;
                w.root_sel = ROOT_BLK;
                w.ld_grant = 1'b1;
                w.tgt_t = PC_DONE;
            end
            PC_F0: begin
                w.rd_sel = RD_BIDX;
                w.ld_blk = 1'b1;
                w.cond = COND_BIDX_OOR;
                w.tgt_t = PC_DONE;
                w.tgt_f = PC_R1;
                w.jump_status = STATUS_RANGE;
            end
            PC_R1: begin
                w.ld_links = 1'b1;
                w.cond = COND_BLK_IS_ROOT;
                w.tgt_t = PC_R3;
                w.tgt_f = PC_R2;
            end
            PC_R2: begin
                w.wn_addr = WN_PV;
                w.wn_data = WND_NX;
                w.wp_addr = WP_NX;
                w.wp_data = WPD_PV;
                w.tgt_t = PC_R4;
            end
            PC_R3: begin
                w.root_sel = ROOT_NX;
                w.wp_addr = WP_NX;
                w.wp_data = WPD_END;
                w.tgt_t = PC_R4;
            end
            PC_R4: begin
                w.wn_addr = WN_BLK;
                w.wn_data = WND_FH;
                w.wp_addr = WP_FH;
                w.wp_data = WPD_BLK;
                w.fh_sel = FH_BLK;
                w.tgt_t = PC_R5;
            end
            PC_R5: begin
                w.wp_addr = WP_BLK;
                w.wp_data = WPD_END;
                w.cond = COND_IS_FREE;
                w.tgt_t = PC_DONE;
                w.tgt_f = PC_L0;
            end
            PC_L0: begin
                w.cond = COND_WALK_END;
                w.tgt_t = PC_DONE;
                w.tgt_f = PC_L1;
            end
            PC_L1: begin
                w.rd_sel = RD_ROOT;
                w.ld_blk = 1'b1;
                w.cnt_inc = 1'b1;
                w.cond = COND_ROOT_OOR;
                w.tgt_t = PC_DONE;
                w.tgt_f = PC_R1;
                w.jump_status = STATUS_RANGE;
            end
            PC_I0: begin
                w.cond = COND_CNT_ZERO;
                w.tgt_t = PC_DONE;
                w.tgt_f = PC_I1;
            end
            PC_I1: begin
                w.wn_addr = WN_IDX;
                w.wn_data = WND_INIT;
                w.wp_addr = WP_IDX;
                w.wp_data = WPD_INIT;
                w.cnt_inc = 1'b1;
                w.cond = COND_INIT_LAST;
                w.tgt_t = PC_I2;
                w.tgt_f = PC_I1;
            end
            PC_I2: begin
                w.fh_sel = FH_ZERO;
                w.tgt_t = PC_DONE;
            end
            default: begin
                w = CW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/ibfla_req_if.sv =====
`default_nettype none

interface ibfla_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] client_root;
    logic [5:0] block_index;

    modport source (output valid, output req_type, output client_root,
                    output block_index, input ready);
    modport sink (input valid, input req_type, input client_root,
                  input block_index, output ready);
endinterface

`default_nettype wire

// ===== design/ibfla_rsp_if.sv =====
`default_nettype none

interface ibfla_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] new_client_root;
    logic [7:0] granted_index;
    logic [1:0] status;

    modport source (output valid, output new_client_root, output granted_index,
                    output status, input ready);
    modport sink (input valid, input new_client_root, input granted_index,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== design/indexed_block_free_list_allocator_unit.sv =====
`default_nettype none

// Block allocator that keeps doubly linked lists of block indices in two
// link memories of MAX_BLOCKS entries: one free list plus client lists whose
// head comes in with each request word and goes back, updated, in the
// response word. A small microprogram steps through one request at a time,
// one step per cycle, limited by the single write port of each link memory.
// Free-all moves the blocks of the client list one by one and stops at the
// end of the list, after MAX_BLOCKS blocks, or at a head out of range; init
// sweeps the effective block count. An alloc on an empty free list, a free
// out of range and an init with a zero count end at their first step. The
// last step of a request waits while the previous response word is still
// unaccepted. Requests are taken only while no request is in progress; a
// waiting response does not block the next request once its work is done.
// Run an init request before any other after reset.
module indexed_block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,
    ibfla_req_if.sink       req,
    ibfla_rsp_if.source     rsp
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    logic [7:0]    next_mem [MAX_BLOCKS];
    logic [7:0]    prev_mem [MAX_BLOCKS];

    logic [6:0]    block_count_reg;
    logic          busy_reg;
    logic [3:0]    pc_reg;
    logic [1:0]    req_type_reg;
    logic [7:0]    root_reg;
    logic [5:0]    bidx_reg;
    logic [7:0]    blk_reg;
    logic [7:0]    nx_reg;
    logic [7:0]    pv_reg;
    logic [7:0]    fh_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    status_reg;
    logic [7:0]    grant_reg;
    logic          rd_ok_reg;
    logic [7:0]    rd_next_reg;
    logic [7:0]    rd_prev_reg;
    logic          out_valid_reg;
    logic [7:0]    out_root_reg;
    logic [7:0]    out_grant_reg;
    logic [1:0]    out_status_reg;

    ibfla_pkg::ctrl_word_t cw;
    logic       in_accept;
    logic       stall;
    logic       step_go;
    logic       finish;
    logic       cond_hit;
    logic [7:0] eff_cnt;
    logic [7:0] cnt_ext;
    logic [7:0] rd_addr;
    logic       rd_en;
    logic [7:0] rd_next;
    logic [7:0] rd_prev;
    logic [7:0] wn_addr;
    logic [7:0] wn_data;
    logic       wn_en;
    logic [7:0] wp_addr;
    logic [7:0] wp_data;
    logic       wp_en;
    logic       init_last;

    function automatic logic in_store(input logic [7:0] v);
        return v < 8'(MAX_BLOCKS);
    endfunction

    assign cw        = ibfla_pkg::rom(pc_reg);
    assign in_accept = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign stall     = cw.fin && out_valid_reg && !rsp.ready;
    assign step_go   = busy_reg && !stall;
    assign finish    = step_go && cw.fin;

    assign rsp.valid           = out_valid_reg;
    assign rsp.new_client_root = out_root_reg;
    assign rsp.granted_index   = out_grant_reg;
    assign rsp.status          = out_status_reg;

    assign eff_cnt   = (8'(block_count_reg) > 8'(MAX_BLOCKS)) ? 8'(MAX_BLOCKS)
                                                              : 8'(block_count_reg);
    assign cnt_ext   = 8'(cnt_reg);
    assign init_last = (cnt_ext + 8'd1) == eff_cnt;
    assign rd_next   = rd_ok_reg ? rd_next_reg : ibfla_pkg::END_MARK;
    assign rd_prev   = rd_ok_reg ? rd_prev_reg : ibfla_pkg::END_MARK;

    always_comb
    begin
        unique case (cw.cond)
            ibfla_pkg::COND_ALWAYS:      cond_hit = 1'b1;
            ibfla_pkg::COND_FH_EMPTY:    cond_hit = fh_reg == ibfla_pkg::END_MARK;
            ibfla_pkg::COND_BIDX_OOR:    cond_hit = 8'(bidx_reg) >= eff_cnt;
            ibfla_pkg::COND_BLK_IS_ROOT: cond_hit = blk_reg == root_reg;
            ibfla_pkg::COND_IS_FREE:     cond_hit = req_type_reg == ibfla_pkg::REQ_FREE;
            ibfla_pkg::COND_WALK_END:    cond_hit = (root_reg == ibfla_pkg::END_MARK)
                                                    || (cnt_ext == 8'(MAX_BLOCKS));
            ibfla_pkg::COND_ROOT_OOR:    cond_hit = root_reg >= eff_cnt;
            ibfla_pkg::COND_CNT_ZERO:    cond_hit = eff_cnt == 8'd0;
            ibfla_pkg::COND_INIT_LAST:   cond_hit = init_last;
            default:                     cond_hit = 1'b1;
        endcase
    end

    always_comb
    begin
        rd_en = 1'b1;
        unique case (cw.rd_sel)
            ibfla_pkg::RD_FH:   rd_addr = fh_reg;
            ibfla_pkg::RD_BIDX: rd_addr = 8'(bidx_reg);
            ibfla_pkg::RD_ROOT: rd_addr = root_reg;
            default:
            begin
                rd_addr = ibfla_pkg::END_MARK;
                rd_en   = 1'b0;
            end
        endcase

        unique case (cw.wn_addr)
            ibfla_pkg::WN_BLK: wn_addr = blk_reg;
            ibfla_pkg::WN_PV:  wn_addr = pv_reg;
            ibfla_pkg::WN_IDX: wn_addr = cnt_ext;
            default:           wn_addr = ibfla_pkg::END_MARK;
        endcase

        unique case (cw.wn_data)
            ibfla_pkg::WND_ROOT: wn_data = root_reg;
            ibfla_pkg::WND_NX:   wn_data = nx_reg;
            ibfla_pkg::WND_FH:   wn_data = fh_reg;
            ibfla_pkg::WND_INIT: wn_data = init_last ? ibfla_pkg::END_MARK
                                                     : cnt_ext + 8'd1;
            default:             wn_data = ibfla_pkg::END_MARK;
        endcase

        unique case (cw.wp_addr)
            ibfla_pkg::WP_BLK:  wp_addr = blk_reg;
            ibfla_pkg::WP_NX:   wp_addr = nx_reg;
            ibfla_pkg::WP_ROOT: wp_addr = root_reg;
            ibfla_pkg::WP_FH:   wp_addr = fh_reg;
            ibfla_pkg::WP_IDX:  wp_addr = cnt_ext;
            default:            wp_addr = ibfla_pkg::END_MARK;
        endcase

        unique case (cw.wp_data)
            ibfla_pkg::WPD_END:  wp_data = ibfla_pkg::END_MARK;
            ibfla_pkg::WPD_BLK:  wp_data = blk_reg;
            ibfla_pkg::WPD_PV:   wp_data = pv_reg;
            ibfla_pkg::WPD_INIT: wp_data = (cnt_ext == 8'd0) ? ibfla_pkg::END_MARK
                                                            : cnt_ext - 8'd1;
            default:             wp_data = ibfla_pkg::END_MARK;
        endcase
    end

    assign wn_en = step_go && (cw.wn_addr != ibfla_pkg::WN_NONE) && in_store(wn_addr);
    assign wp_en = step_go && (cw.wp_addr != ibfla_pkg::WP_NONE) && in_store(wp_addr);

    always_ff @(posedge clk)
    begin
        if (wn_en)
        begin
            next_mem[wn_addr[AW-1:0]] <= wn_data;
        end
        if (wp_en)
        begin
            prev_mem[wp_addr[AW-1:0]] <= wp_data;
        end
        if (step_go && rd_en && in_store(rd_addr))
        begin
            rd_next_reg <= next_mem[rd_addr[AW-1:0]];
            rd_prev_reg <= prev_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_type_reg <= req.req_type;
            bidx_reg     <= req.block_index;
        end
        if (step_go && cw.ld_blk)
        begin
            blk_reg <= rd_addr;
        end
        if (step_go && cw.ld_links)
        begin
            nx_reg <= rd_next;
            pv_reg <= rd_prev;
        end
        if (finish)
        begin
            out_root_reg   <= root_reg;
            out_grant_reg  <= grant_reg;
            out_status_reg <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= 7'd64;
            busy_reg        <= 1'b0;
            pc_reg          <= ibfla_pkg::PC_DONE;
            root_reg        <= ibfla_pkg::END_MARK;
            fh_reg          <= ibfla_pkg::END_MARK;
            cnt_reg         <= '0;
            status_reg      <= ibfla_pkg::STATUS_OK;
            grant_reg       <= ibfla_pkg::END_MARK;
            rd_ok_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                block_count_reg <= cfg_wr_data;
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_accept)
            begin
                busy_reg   <= 1'b1;
                pc_reg     <= ibfla_pkg::entry_pc(req.req_type);
                root_reg   <= req.client_root;
                cnt_reg    <= '0;
                status_reg <= ibfla_pkg::STATUS_OK;
                grant_reg  <= ibfla_pkg::END_MARK;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (step_go)
            begin
                if (cond_hit)
                begin
                    pc_reg     <= cw.tgt_t;
                    status_reg <= cw.jump_status;
                end
                else
                begin
                    pc_reg <= cw.tgt_f;
                end

                if (cw.rd_sel != ibfla_pkg::RD_NONE)
                begin
                    rd_ok_reg <= in_store(rd_addr);
                end

                if (cw.cnt_inc)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end

                unique case (cw.fh_sel)
                    ibfla_pkg::FH_NX:   fh_reg <= nx_reg;
                    ibfla_pkg::FH_BLK:  fh_reg <= blk_reg;
                    ibfla_pkg::FH_ZERO: fh_reg <= 8'd0;
                    default:            fh_reg <= fh_reg;
                endcase

                unique case (cw.root_sel)
                    ibfla_pkg::ROOT_NX:  root_reg <= nx_reg;
                    ibfla_pkg::ROOT_BLK: root_reg <= blk_reg;
                    default:             root_reg <= root_reg;
                endcase

                if (cw.ld_grant)
                begin
                    grant_reg <= blk_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire
